[rtl/core/assert_macros.svh]
// Assertion helpers for the core RTL.
// Each check samples on the rising edge of clk and is off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, pre, post, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

[rtl/core/usbe0_pkg.sv]
package usbe0_pkg;

  // Control endpoint mode
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_TX    = 3'b010,
    MODE_STALL = 3'b100
  } ctl_mode_t;

  // Classified request, as handed from the front to the back
  typedef enum logic [3:0] {
    CMD_STALL,
    CMD_REPLY,
    CMD_STATUS_EP,
    CMD_GET_CONFIG,
    CMD_CLEAR_HALT,
    CMD_SET_HALT,
    CMD_SET_ADDRESS,
    CMD_SET_CONFIG,
    CMD_SET_INTERFACE
  } cmd_t;

  // Standard request codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'h0A;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'h0B;
  localparam logic [7:0] REQ_GET_MAX_LUN       = 8'hFE;

  // Request types that get status accepts
  localparam logic [7:0] RTYPE_DEVICE_IN    = 8'h80;
  localparam logic [7:0] RTYPE_INTERFACE_IN = 8'h81;
  localparam logic [7:0] RTYPE_ENDPOINT_IN  = 8'h82;

  // Endpoint addresses
  localparam logic [7:0] EP_IN1  = 8'h81;
  localparam logic [7:0] EP_OUT2 = 8'h02;

  // Descriptor types
  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;

  // Reply sources
  localparam logic [2:0] SRC_ZERO   = 3'd0;
  localparam logic [2:0] SRC_ONES   = 3'd1;
  localparam logic [2:0] SRC_DEVICE = 3'd2;
  localparam logic [2:0] SRC_CONFIG = 3'd3;
  localparam logic [2:0] SRC_STRING = 3'd4;

  // Endpoint status codes
  localparam logic [1:0] EPS_IDLE  = 2'd0;
  localparam logic [1:0] EPS_STALL = 2'd1;
  localparam logic [1:0] EPS_HALT  = 2'd2;

  // Device state codes
  localparam logic [1:0] STATE_ATTACHED   = 2'd0;
  localparam logic [1:0] STATE_DEFAULT    = 2'd1;
  localparam logic [1:0] STATE_ADDRESSED  = 2'd2;
  localparam logic [1:0] STATE_CONFIGURED = 2'd3;

  localparam logic [15:0] DEVICE_DESC_BYTES = 16'd18;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // One classified word in the queue
  typedef struct packed {
    logic        setup_end;
    logic        stall_sent;
    logic        pkt_ready;
    cmd_t        cmd;
    logic [15:0] wlen;
    logic [2:0]  src;
    logic [15:0] len;
    logic [7:0]  off;
    logic        ep_in1;
    logic        ep_out2;
    logic [6:0]  addr;
    logic        cfg_on;
  } qent_t;

endpackage

[rtl/core/usbe0_in_if.sv]
interface usbe0_in_if;
  logic        valid;
  logic        ready;
  logic        setup_end_flag;
  logic        stall_sent_flag;
  logic        packet_ready_flag;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [7:0]  value_low;
  logic [7:0]  value_high;
  logic [7:0]  index_low;
  logic [15:0] requested_bytes;

  modport source (
    output valid, setup_end_flag, stall_sent_flag, packet_ready_flag, request_type,
           request_code, value_low, value_high, index_low, requested_bytes,
    input  ready
  );

  modport sink (
    input  valid, setup_end_flag, stall_sent_flag, packet_ready_flag, request_type,
           request_code, value_low, value_high, index_low, requested_bytes,
    output ready
  );
endinterface

[rtl/core/usbe0_out_if.sv]
interface usbe0_out_if;
  logic        valid;
  logic        ready;
  logic        stall_request;
  logic        setup_acknowledged;
  logic        packet_valid;
  logic [2:0]  packet_source;
  logic [15:0] packet_offset;
  logic [6:0]  packet_bytes;
  logic        transfer_done;
  logic        address_write;
  logic [6:0]  device_address;
  logic [1:0]  device_state_out;
  logic [1:0]  in_endpoint_status;
  logic [1:0]  out_endpoint_status;

  modport source (
    output valid, stall_request, setup_acknowledged, packet_valid, packet_source,
           packet_offset, packet_bytes, transfer_done, address_write, device_address,
           device_state_out, in_endpoint_status, out_endpoint_status,
    input  ready
  );

  modport sink (
    input  valid, stall_request, setup_acknowledged, packet_valid, packet_source,
           packet_offset, packet_bytes, transfer_done, address_write, device_address,
           device_state_out, in_endpoint_status, out_endpoint_status,
    output ready
  );
endinterface

[rtl/core/usb_ep0_standard_request_engine_unit.sv]
// A word is decoded and written into the queue when it is accepted; the back then
// pops it and registers its result in the output register, which is offered on res.
// Throughput: one event word per cycle; a held result fills the two-word queue,
// after which the input stalls until the result is taken.
// Reset (rst, synchronous, active high): endpoint 0 idle, both data endpoints
// stalled, device attached, reply counters zero, queue and result register empty.
module usb_ep0_standard_request_engine_unit #(
  parameter int MAX_PACKET        = 64,
  parameter int CONFIG_DESC_BYTES = 32
) (
  input logic         clk,
  input logic         rst,
  usbe0_in_if.sink    evt,
  usbe0_out_if.source res
);

  usbe0_pkg::qent_t wdata;
  usbe0_pkg::qent_t rdata;
  logic             push;
  logic             pop;
  logic             full;
  logic             q_valid;

  usbe0_front #(
    .CONFIG_DESC_BYTES(CONFIG_DESC_BYTES)
  ) u_front (
    .evt  (evt),
    .full (full),
    .push (push),
    .entry(wdata)
  );

  usbe0_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (wdata),
    .full   (full),
    .q_valid(q_valid),
    .pop    (pop),
    .rdata  (rdata)
  );

  usbe0_back #(
    .MAX_PACKET(MAX_PACKET)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .entry  (rdata),
    .pop    (pop),
    .res    (res)
  );

endmodule

[rtl/core/usbe0_front.sv]
module usbe0_front #(
  parameter int CONFIG_DESC_BYTES = 32
) (
  usbe0_in_if.sink         evt,
  input  logic             full,
  output logic             push,
  output usbe0_pkg::qent_t entry
);

  localparam logic [15:0] CfgLen = 16'(CONFIG_DESC_BYTES);

  logic ep_in1;
  logic ep_out2;
  logic halt_ok;

  // Take a word whenever the queue has room
  assign evt.ready = !full;
  assign push      = evt.valid && !full;

  assign ep_in1  = (evt.index_low == usbe0_pkg::EP_IN1);
  assign ep_out2 = (evt.index_low == usbe0_pkg::EP_OUT2);
  assign halt_ok = evt.request_type[1] && (evt.value_low == 8'd0) && (ep_in1 || ep_out2);

  // Classify the setup packet; state-dependent parts are left to the back
  always_comb begin
    entry            = '0;
    entry.setup_end  = evt.setup_end_flag;
    entry.stall_sent = evt.stall_sent_flag;
    entry.pkt_ready  = evt.packet_ready_flag;
    entry.wlen       = evt.requested_bytes;
    entry.ep_in1     = ep_in1;
    entry.ep_out2    = ep_out2;
    entry.addr       = evt.value_low[6:0];
    entry.cfg_on     = (evt.value_low != 8'd0);
    entry.cmd        = usbe0_pkg::CMD_STALL;
    entry.src        = usbe0_pkg::SRC_ZERO;
    entry.len        = 16'd0;
    entry.off        = 8'd0;
    case (evt.request_code)
      usbe0_pkg::REQ_GET_STATUS: begin
        entry.len = 16'd2;
        if (evt.request_type inside {usbe0_pkg::RTYPE_DEVICE_IN,
                                     usbe0_pkg::RTYPE_INTERFACE_IN}) begin
          entry.cmd = usbe0_pkg::CMD_REPLY;
        end else if (evt.request_type == usbe0_pkg::RTYPE_ENDPOINT_IN) begin
          entry.cmd = usbe0_pkg::CMD_STATUS_EP;
        end
      end
      usbe0_pkg::REQ_CLEAR_FEATURE: begin
        if (halt_ok) entry.cmd = usbe0_pkg::CMD_CLEAR_HALT;
      end
      usbe0_pkg::REQ_SET_FEATURE: begin
        if (halt_ok) entry.cmd = usbe0_pkg::CMD_SET_HALT;
      end
      usbe0_pkg::REQ_SET_ADDRESS: begin
        entry.cmd = usbe0_pkg::CMD_SET_ADDRESS;
      end
      usbe0_pkg::REQ_GET_DESCRIPTOR: begin
        case (evt.value_high)
          usbe0_pkg::DESC_DEVICE: begin
            entry.cmd = usbe0_pkg::CMD_REPLY;
            entry.src = usbe0_pkg::SRC_DEVICE;
            entry.len = (evt.requested_bytes > usbe0_pkg::DEVICE_DESC_BYTES) ?
                        usbe0_pkg::DEVICE_DESC_BYTES : evt.requested_bytes;
          end
          usbe0_pkg::DESC_CONFIG: begin
            entry.cmd = usbe0_pkg::CMD_REPLY;
            entry.src = usbe0_pkg::SRC_CONFIG;
            entry.len = (evt.requested_bytes > CfgLen) ? CfgLen : evt.requested_bytes;
          end
          usbe0_pkg::DESC_STRING: begin
            entry.cmd = usbe0_pkg::CMD_REPLY;
            entry.src = usbe0_pkg::SRC_STRING;
            entry.len = evt.requested_bytes;
            entry.off = evt.value_low;
          end
          default: entry.cmd = usbe0_pkg::CMD_STALL;
        endcase
      end
      usbe0_pkg::REQ_GET_CONFIGURATION: begin
        entry.cmd = usbe0_pkg::CMD_GET_CONFIG;
        entry.len = 16'd1;
      end
      usbe0_pkg::REQ_SET_CONFIGURATION: begin
        entry.cmd = usbe0_pkg::CMD_SET_CONFIG;
      end
      usbe0_pkg::REQ_GET_INTERFACE, usbe0_pkg::REQ_GET_MAX_LUN: begin
        entry.cmd = usbe0_pkg::CMD_REPLY;
        entry.len = 16'd1;
      end
      usbe0_pkg::REQ_SET_INTERFACE: begin
        entry.cmd = usbe0_pkg::CMD_SET_INTERFACE;
      end
      default: entry.cmd = usbe0_pkg::CMD_STALL;
    endcase
  end

endmodule

[rtl/core/usbe0_queue.sv]
module usbe0_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  usbe0_pkg::qent_t wdata,
  output logic             full,
  output logic             q_valid,
  input  logic             pop,
  output usbe0_pkg::qent_t rdata
);

  usbe0_pkg::qent_t                   mem [usbe0_pkg::Q_DEPTH];
  logic [usbe0_pkg::Q_PTR_W-1:0]      wr_ptr;
  logic [usbe0_pkg::Q_PTR_W-1:0]      rd_ptr;
  logic [usbe0_pkg::Q_CNT_W-1:0]      count;

  assign full    = (count == usbe0_pkg::Q_CNT_W'(usbe0_pkg::Q_DEPTH));
  assign q_valid = (count != '0);
  assign rdata   = mem[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[rtl/core/usbe0_back.sv]
`include "assert_macros.svh"

module usbe0_back #(
  parameter int MAX_PACKET = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  usbe0_pkg::qent_t entry,
  output logic             pop,
  usbe0_out_if.source      res
);

  localparam logic [15:0] MaxPkt16 = 16'(MAX_PACKET);
  localparam logic [6:0]  MaxPkt7  = 7'(MAX_PACKET);

  typedef struct packed {
    logic        stall;
    logic        ack;
    logic        pvalid;
    logic [2:0]  psrc;
    logic [15:0] poff;
    logic [6:0]  pbytes;
    logic        done;
    logic        awrite;
    logic [6:0]  addr;
    logic [1:0]  dev;
    logic [1:0]  in_eps;
    logic [1:0]  out_eps;
  } rsp_t;

  // Endpoint-0 state
  usbe0_pkg::ctl_mode_t ctl_mode, ctl_mode_next;
  logic [1:0]  in_mode, in_mode_next;
  logic [1:0]  out_mode, out_mode_next;
  logic [1:0]  dev_state, dev_state_next;
  logic [15:0] remaining, remaining_next;
  logic [15:0] sent, sent_next;
  logic [2:0]  rsrc, rsrc_next;
  logic [15:0] roff, roff_next;
  logic [15:0] latched, latched_next;

  // Output register
  logic out_valid;
  rsp_t out_word;
  rsp_t rsp_next;

  // Values after the setup decode, before the packet step
  usbe0_pkg::ctl_mode_t mode_a, mode_e;
  logic [2:0]  src_e;
  logic [15:0] off_e;
  logic [15:0] rem_e;
  logic [15:0] sent_e;
  logic        in_halt_hit;

  // Pop when the output register is free or being emptied
  assign pop = q_valid && (!out_valid || res.ready);

  assign in_halt_hit = (entry.ep_in1 && (in_mode == usbe0_pkg::EPS_HALT)) ||
                       (entry.ep_out2 && (out_mode == usbe0_pkg::EPS_HALT));

  // Decode the setup word against the current state
  always_comb begin
    rsp_next       = '0;
    mode_a         = (entry.setup_end || entry.stall_sent) ? usbe0_pkg::MODE_IDLE : ctl_mode;
    mode_e         = mode_a;
    src_e          = rsrc;
    off_e          = roff;
    rem_e          = remaining;
    sent_e         = sent;
    latched_next   = latched;
    in_mode_next   = in_mode;
    out_mode_next  = out_mode;
    dev_state_next = dev_state;
    if (entry.pkt_ready && (mode_a == usbe0_pkg::MODE_IDLE)) begin
      latched_next = entry.wlen;
      case (entry.cmd)
        usbe0_pkg::CMD_REPLY, usbe0_pkg::CMD_STATUS_EP, usbe0_pkg::CMD_GET_CONFIG: begin
          src_e = entry.src;
          if (entry.cmd == usbe0_pkg::CMD_STATUS_EP && in_halt_hit) begin
            src_e = usbe0_pkg::SRC_ONES;
          end
          if (entry.cmd == usbe0_pkg::CMD_GET_CONFIG &&
              dev_state == usbe0_pkg::STATE_CONFIGURED) begin
            src_e = usbe0_pkg::SRC_ONES;
          end
          off_e        = {8'd0, entry.off};
          rem_e        = entry.len;
          sent_e       = 16'd0;
          mode_e       = usbe0_pkg::MODE_TX;
          rsp_next.ack = 1'b1;
        end
        usbe0_pkg::CMD_CLEAR_HALT, usbe0_pkg::CMD_SET_HALT: begin
          if (entry.ep_in1) begin
            in_mode_next = (entry.cmd == usbe0_pkg::CMD_CLEAR_HALT) ?
                           usbe0_pkg::EPS_IDLE : usbe0_pkg::EPS_HALT;
          end else begin
            out_mode_next = (entry.cmd == usbe0_pkg::CMD_CLEAR_HALT) ?
                            usbe0_pkg::EPS_IDLE : usbe0_pkg::EPS_HALT;
          end
          rsp_next.ack  = 1'b1;
          rsp_next.done = 1'b1;
        end
        usbe0_pkg::CMD_SET_ADDRESS: begin
          if (entry.addr != 7'd0) begin
            dev_state_next  = usbe0_pkg::STATE_ADDRESSED;
            rsp_next.awrite = 1'b1;
            rsp_next.addr   = entry.addr;
          end else begin
            dev_state_next = usbe0_pkg::STATE_DEFAULT;
          end
          mode_e        = usbe0_pkg::MODE_IDLE;
          rsp_next.ack  = 1'b1;
          rsp_next.done = 1'b1;
        end
        usbe0_pkg::CMD_SET_CONFIG: begin
          if (entry.cfg_on) begin
            dev_state_next = usbe0_pkg::STATE_CONFIGURED;
            in_mode_next   = usbe0_pkg::EPS_IDLE;
            out_mode_next  = usbe0_pkg::EPS_IDLE;
          end else begin
            dev_state_next = usbe0_pkg::STATE_ADDRESSED;
            in_mode_next   = usbe0_pkg::EPS_STALL;
            out_mode_next  = usbe0_pkg::EPS_STALL;
          end
          rsp_next.ack  = 1'b1;
          rsp_next.done = 1'b1;
        end
        usbe0_pkg::CMD_SET_INTERFACE: begin
          rsp_next.ack  = 1'b1;
          rsp_next.done = 1'b1;
        end
        default: begin
          rsp_next.stall = 1'b1;
          mode_e         = usbe0_pkg::MODE_STALL;
        end
      endcase
    end

    // Send one packet of the reply
    ctl_mode_next  = mode_e;
    rsrc_next      = src_e;
    roff_next      = off_e;
    remaining_next = rem_e;
    sent_next      = sent_e;
    if (mode_e == usbe0_pkg::MODE_TX) begin
      rsp_next.pvalid = 1'b1;
      rsp_next.psrc   = src_e;
      rsp_next.poff   = off_e;
      if (rem_e >= MaxPkt16) begin
        rsp_next.pbytes = MaxPkt7;
        roff_next       = off_e + MaxPkt16;
        remaining_next  = rem_e - MaxPkt16;
        sent_next       = sent_e + MaxPkt16;
      end else begin
        rsp_next.pbytes = rem_e[6:0];
        rsp_next.done   = 1'b1;
        ctl_mode_next   = usbe0_pkg::MODE_IDLE;
      end
      if (sent_next == latched_next) begin
        rsp_next.done = 1'b1;
        ctl_mode_next = usbe0_pkg::MODE_IDLE;
      end
    end
    rsp_next.dev     = dev_state_next;
    rsp_next.in_eps  = in_mode_next;
    rsp_next.out_eps = out_mode_next;
  end

  // Commit state on each popped word
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mode  <= usbe0_pkg::MODE_IDLE;
      in_mode   <= usbe0_pkg::EPS_STALL;
      out_mode  <= usbe0_pkg::EPS_STALL;
      dev_state <= usbe0_pkg::STATE_ATTACHED;
      remaining <= '0;
      sent      <= '0;
      rsrc      <= '0;
      roff      <= '0;
      latched   <= '0;
    end else if (pop) begin
      ctl_mode  <= ctl_mode_next;
      in_mode   <= in_mode_next;
      out_mode  <= out_mode_next;
      dev_state <= dev_state_next;
      remaining <= remaining_next;
      sent      <= sent_next;
      rsrc      <= rsrc_next;
      roff      <= roff_next;
      latched   <= latched_next;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_word <= rsp_next;
  end

  assign res.valid               = out_valid;
  assign res.stall_request       = out_word.stall;
  assign res.setup_acknowledged  = out_word.ack;
  assign res.packet_valid        = out_word.pvalid;
  assign res.packet_source       = out_word.psrc;
  assign res.packet_offset       = out_word.poff;
  assign res.packet_bytes        = out_word.pbytes;
  assign res.transfer_done       = out_word.done;
  assign res.address_write       = out_word.awrite;
  assign res.device_address      = out_word.addr;
  assign res.device_state_out    = out_word.dev;
  assign res.in_endpoint_status  = out_word.in_eps;
  assign res.out_endpoint_status = out_word.out_eps;

  `ASSERT_NEVER(a_stall_with_ack,
    res.valid && res.stall_request && res.setup_acknowledged, "stall and acknowledge in one word")
  `ASSERT_IMPLIES(a_packet_size, res.valid && res.packet_valid,
    res.packet_bytes <= MaxPkt7, "packet longer than max packet")
  `ASSERT_IMPLIES(a_no_packet_clean, res.valid && !res.packet_valid,
    res.packet_bytes == 7'd0 && res.packet_offset == 16'd0, "packet fields set without a packet")
  `ASSERT_NEXT(a_stall_holds, pop && rsp_next.stall,
    ctl_mode == usbe0_pkg::MODE_STALL, "stall did not enter stall mode")

endmodule
